[hw/rtl/anft_pkg.sv]
// ----------------------------------------------------------------------------
// anft_pkg
// Shared widths, defaults and action codes for the alpha-nearness block.
// ----------------------------------------------------------------------------
package anft_pkg;

    // Field widths of the channel words
    localparam int ACTION_W = 2;
    localparam int VERT_W   = 6;
    localparam int DIST_W   = 24;
    localparam int CFG_W    = 7;

    // Defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int DIST_BITS_DEF    = 24;

    // Vertex count after reset
    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(64);
    localparam int               VCOUNT_MIN   = 3;

    // Action codes of an input word
    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

endpackage

[hw/rtl/anft_if.sv]
// ----------------------------------------------------------------------------
// anft_if
// Valid/ready channels of the alpha-nearness block: input words, result
// words and the vertex count register write.
// ----------------------------------------------------------------------------
interface anft_in_if
    import anft_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VERT_W-1:0]   row_vertex;
    logic [VERT_W-1:0]   col_vertex;
    logic [DIST_W-1:0]   distance_value;

    modport source (output valid, action, row_vertex, col_vertex, distance_value,
                    input ready);
    modport sink   (input valid, action, row_vertex, col_vertex, distance_value,
                    output ready);
endinterface

interface anft_out_if
    import anft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] alpha_value;
    logic [VERT_W-1:0] special_vertex;
    logic [VERT_W-1:0] special_neighbor;
    logic              not_computed;

    modport source (output valid, alpha_value, special_vertex, special_neighbor,
                    not_computed, input ready);
    modport sink   (input valid, alpha_value, special_vertex, special_neighbor,
                    not_computed, output ready);
endinterface

interface anft_cfg_if
    import anft_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

[hw/rtl/anft_ram.sv]
// ----------------------------------------------------------------------------
// anft_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module anft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/alpha_nearness_from_one_tree.sv]
// ----------------------------------------------------------------------------
// alpha_nearness_from_one_tree
// Distance matrix store, minimum one-tree builder and alpha-nearness reader.
// ----------------------------------------------------------------------------
// Distance writes and alpha reads stream one word per cycle while the block
// is idle and the output register is not stalled; a read's result goes to the
// registered output word. A compute word holds the input channel while the
// block builds the Prim tree with one-per-cycle scans over the distance RAM,
// runs the special-leaf search, and then fills beta over every vertex pair of
// the insertion order one pair at a time, bound by the chain of reads
// order -> parent -> beta/distance. Distances and beta values sit in symmetric
// RAMs addressed by the ordered pair, so one write covers both (row,col) and
// (col,row). There is no clearing pass.
// ----------------------------------------------------------------------------
module alpha_nearness_from_one_tree
    import anft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int DIST_BITS    = DIST_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    anft_in_if.sink     i_in,
    anft_cfg_if.sink    i_cfg,
    anft_out_if.source  o_out
);

    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int PW         = 2 * VW;
    localparam int PAIR_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int CW         = $clog2(MAX_VERTICES + 1);

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_INIT    = 19'h00002,
        S_COMMIT  = 19'h00004,
        S_UPD     = 19'h00008,
        S_LEAF    = 19'h00010,
        S_SN_PAR  = 19'h00020,
        S_SN_LAT  = 19'h00040,
        S_SN_SCAN = 19'h00080,
        S_SN_END  = 19'h00100,
        S_SP_PAR  = 19'h00200,
        S_SP_GET  = 19'h00400,
        S_BROW    = 19'h00800,
        S_A_ORD   = 19'h01000,
        S_A_CHK   = 19'h02000,
        S_B_ORD   = 19'h04000,
        S_B_PAR   = 19'h08000,
        S_B_MEM   = 19'h10000,
        S_B_WR    = 19'h20000,
        S_DONE    = 19'h40000
    } t_state;

    function automatic logic [PW-1:0] pair_addr(input logic [VW-1:0] a,
                                                input logic [VW-1:0] b);
        return (a < b) ? {a, b} : {b, a};
    endfunction

    // Control and datapath registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_vc;
    logic                r_result_valid;
    logic [VW-1:0]       r_special, r_neighbor;
    logic [CW-1:0]       r_cnt, r_step, r_v, r_a, r_b;
    logic                r_dv;
    logic [VW-1:0]       r_didx;
    logic [VW-1:0]       r_pick, r_best;
    logic [DIST_BITS-1:0] r_bkey;
    logic                r_bfound;
    logic [MAX_VERTICES-1:0] r_in_tree, r_is_par;
    logic [VW-1:0]       r_par, r_sw, r_s, r_sn, r_spar;
    logic [DIST_BITS-1:0] r_smin, r_best_d, r_dpar;
    logic                r_sfound, r_found;
    logic [VW-1:0]       r_oi, r_oj, r_p;
    logic                r_pend, r_pend_ok, r_pend_diag, r_pend_nc;
    logic                r_o_valid;
    logic [DIST_W-1:0]   r_o_alpha;
    logic [VERT_W-1:0]   r_o_special, r_o_neighbor;
    logic                r_o_nc;

    // RAM ports
    logic                 dist_we, dist_re, beta_we, beta_re;
    logic [PW-1:0]        dist_waddr, dist_raddr, beta_waddr, beta_raddr;
    logic [DIST_BITS-1:0] dist_wdata, dist_rdata, beta_wdata, beta_rdata;
    logic                 key_we, key_re, par_we, par_re, ord_we, ord_re;
    logic [VW-1:0]        key_waddr, key_raddr, par_waddr, par_raddr;
    logic [VW-1:0]        ord_waddr, ord_raddr;
    logic [DIST_BITS-1:0] key_wdata, key_rdata;
    logic [VW-1:0]        par_wdata, par_rdata, ord_wdata, ord_rdata;

    // Decode and misc
    logic [CW-1:0]        n_used;
    logic [VW-1:0]        in_r, in_c;
    logic                 in_range, in_fire, out_free, out_load;
    logic                 cnt_live, stream_end;
    logic [DIST_BITS-1:0] walk_beta, walk_max, pend_beta, pend_alpha, upd_key;
    t_action              in_act;

    // Saturate the vertex count to the legal range
    always_comb begin
        if (32'(r_vc) < VCOUNT_MIN) begin
            n_used = CW'(VCOUNT_MIN);
        end else if (32'(r_vc) > MAX_VERTICES) begin
            n_used = CW'(MAX_VERTICES);
        end else begin
            n_used = CW'(r_vc);
        end
    end

    assign in_act   = t_action'(i_in.action);
    assign in_r     = VW'(i_in.row_vertex);
    assign in_c     = VW'(i_in.col_vertex);
    assign in_range = (32'(i_in.row_vertex) < MAX_VERTICES)
                   && (32'(i_in.col_vertex) < MAX_VERTICES);
    assign out_free = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_pend || out_free);
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cnt_live   = r_cnt < n_used;
    assign stream_end = !cnt_live && !r_dv;
    assign out_load   = (r_pend && out_free) || (r_state == S_DONE && out_free);

    // Alpha of a pending read, diagonal beta is zero
    assign pend_beta  = r_pend_diag ? '0 : beta_rdata;
    assign pend_alpha = (r_pend_ok && dist_rdata > pend_beta)
                        ? dist_rdata - pend_beta : '0;

    // Beta walk: max of the parent's beta and the tree edge to the parent
    assign walk_beta = (r_oi == r_p) ? '0 : beta_rdata;
    assign walk_max  = (dist_rdata > walk_beta) ? dist_rdata : walk_beta;

    // Prim key after relaxation through the newest tree vertex
    assign upd_key = (dist_rdata < key_rdata) ? dist_rdata : key_rdata;

    // Steer the RAM ports
    always_comb begin
        dist_we    = 1'b0;
        dist_waddr = pair_addr(in_r, in_c);
        dist_wdata = DIST_BITS'(i_in.distance_value);
        dist_re    = 1'b0;
        dist_raddr = pair_addr(in_r, in_c);
        beta_we    = 1'b0;
        beta_waddr = pair_addr(r_s, r_cnt[VW-1:0]);
        beta_wdata = (r_cnt[VW-1:0] == r_spar) ? r_dpar : r_best_d;
        beta_re    = 1'b0;
        beta_raddr = pair_addr(in_r, in_c);
        key_we     = 1'b0;
        key_waddr  = r_didx;
        key_wdata  = dist_rdata;
        key_re     = 1'b0;
        key_raddr  = r_cnt[VW-1:0];
        par_we     = 1'b0;
        par_waddr  = r_didx;
        par_wdata  = '0;
        par_re     = 1'b0;
        par_raddr  = r_cnt[VW-1:0];
        ord_we     = 1'b0;
        ord_waddr  = r_step[VW-1:0];
        ord_wdata  = r_best;
        ord_re     = 1'b0;
        ord_raddr  = r_a[VW-1:0];
        case (r_state)
            S_IDLE: begin
                dist_we = in_fire && in_act == ACT_WRITE && in_range;
                dist_re = in_fire && in_act == ACT_READ;
                beta_re = in_fire && in_act == ACT_READ;
                ord_we    = in_fire && in_act == ACT_COMPUTE;
                ord_waddr = '0;
                ord_wdata = '0;
            end
            S_INIT: begin
                dist_re    = cnt_live;
                dist_raddr = pair_addr('0, r_cnt[VW-1:0]);
                key_we     = r_dv;
                par_we     = r_dv;
            end
            S_COMMIT: begin
                ord_we = 1'b1;
            end
            S_UPD: begin
                dist_re    = cnt_live;
                dist_raddr = pair_addr(r_pick, r_cnt[VW-1:0]);
                key_re     = cnt_live;
                key_we     = r_dv && !r_in_tree[r_didx] && dist_rdata < key_rdata;
                par_we     = key_we;
                par_wdata  = r_pick;
            end
            S_LEAF: begin
                par_re = cnt_live;
            end
            S_SN_PAR: begin
                par_re    = r_v != n_used && !r_is_par[r_v[VW-1:0]];
                par_raddr = r_v[VW-1:0];
            end
            S_SN_SCAN: begin
                dist_re    = cnt_live;
                dist_raddr = pair_addr(r_v[VW-1:0], r_cnt[VW-1:0]);
            end
            S_SP_PAR: begin
                dist_re    = 1'b1;
                dist_raddr = pair_addr(r_s, r_spar);
            end
            S_BROW: begin
                beta_we = cnt_live && r_cnt[VW-1:0] != r_s;
            end
            S_A_ORD: begin
                ord_re = r_a != n_used;
            end
            S_B_ORD: begin
                ord_re    = r_b != n_used;
                ord_raddr = r_b[VW-1:0];
            end
            S_B_PAR: begin
                par_re    = ord_rdata != r_s;
                par_raddr = ord_rdata;
            end
            S_B_MEM: begin
                beta_re    = 1'b1;
                beta_raddr = pair_addr(r_oi, par_rdata);
                dist_re    = 1'b1;
                dist_raddr = pair_addr(r_oj, par_rdata);
            end
            S_B_WR: begin
                beta_we    = 1'b1;
                beta_waddr = pair_addr(r_oi, r_oj);
                beta_wdata = walk_max;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_fire && in_act == ACT_COMPUTE) n_state = S_INIT;
            S_INIT:    if (stream_end) n_state = S_COMMIT;
            S_COMMIT:  n_state = (r_step == n_used - CW'(1)) ? S_LEAF : S_UPD;
            S_UPD:     if (stream_end) n_state = S_COMMIT;
            S_LEAF:    if (stream_end) n_state = S_SN_PAR;
            S_SN_PAR: begin
                if (r_v == n_used) begin
                    n_state = S_SP_PAR;
                end else if (!r_is_par[r_v[VW-1:0]]) begin
                    n_state = S_SN_LAT;
                end
            end
            S_SN_LAT:  n_state = S_SN_SCAN;
            S_SN_SCAN: if (stream_end) n_state = S_SN_END;
            S_SN_END:  n_state = S_SN_PAR;
            S_SP_PAR:  n_state = S_SP_GET;
            S_SP_GET:  n_state = S_BROW;
            S_BROW:    if (!cnt_live) n_state = S_A_ORD;
            S_A_ORD:   n_state = (r_a == n_used) ? S_DONE : S_A_CHK;
            S_A_CHK:   n_state = (ord_rdata == r_s) ? S_A_ORD : S_B_ORD;
            S_B_ORD:   n_state = (r_b == n_used) ? S_A_ORD : S_B_PAR;
            S_B_PAR:   n_state = (ord_rdata == r_s) ? S_B_ORD : S_B_MEM;
            S_B_MEM:   n_state = S_B_WR;
            S_B_WR:    n_state = S_B_ORD;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vc           <= VCOUNT_RESET;
            r_result_valid <= 1'b0;
            r_special      <= '0;
            r_neighbor     <= '0;
            r_in_tree      <= '0;
            r_pend         <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            // Register write or distance write drops the last result
            if (i_cfg.valid && i_cfg.ready) begin
                r_vc           <= i_cfg.vertex_count;
                r_result_valid <= 1'b0;
            end
            if (in_fire && in_act == ACT_WRITE) begin
                r_result_valid <= 1'b0;
            end
            // Hold a read until the output register frees up
            if (in_fire && in_act == ACT_READ) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (r_state == S_IDLE && in_fire && in_act == ACT_COMPUTE) begin
                r_in_tree <= MAX_VERTICES'(1);
            end
            if (r_state == S_COMMIT) begin
                r_in_tree[r_best] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_special      <= r_s;
                r_neighbor     <= r_sn;
                r_result_valid <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Capture a read at acceptance
        if (in_fire && in_act == ACT_READ) begin
            r_pend_ok   <= r_result_valid && 32'(i_in.row_vertex) < 32'(n_used)
                        && 32'(i_in.col_vertex) < 32'(n_used);
            r_pend_diag <= in_r == in_c;
            r_pend_nc   <= !r_result_valid;
        end

        // Load the output word
        if (r_pend && out_free) begin
            r_o_alpha    <= DIST_W'(pend_alpha);
            r_o_special  <= VERT_W'(r_special);
            r_o_neighbor <= VERT_W'(r_neighbor);
            r_o_nc       <= r_pend_nc;
        end else if (r_state == S_DONE && out_free) begin
            r_o_alpha    <= '0;
            r_o_special  <= VERT_W'(r_s);
            r_o_neighbor <= VERT_W'(r_sn);
            r_o_nc       <= 1'b0;
        end

        // Advance the streaming counter and its delayed copy
        r_dv   <= cnt_live;
        r_didx <= r_cnt[VW-1:0];
        if (cnt_live) begin
            r_cnt <= r_cnt + CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                r_cnt    <= '0;
                r_dv     <= 1'b0;
                r_bfound <= 1'b0;
                r_step   <= CW'(1);
            end
            S_INIT: begin
                if (r_dv && r_didx != '0 && (!r_bfound || dist_rdata < r_bkey)) begin
                    r_bfound <= 1'b1;
                    r_bkey   <= dist_rdata;
                    r_best   <= r_didx;
                end
            end
            S_COMMIT: begin
                r_pick   <= r_best;
                r_cnt    <= '0;
                r_dv     <= 1'b0;
                r_bfound <= 1'b0;
                r_is_par <= '0;
                r_step   <= r_step + CW'(1);
            end
            S_UPD: begin
                if (r_dv && !r_in_tree[r_didx] && (!r_bfound || upd_key < r_bkey)) begin
                    r_bfound <= 1'b1;
                    r_bkey   <= upd_key;
                    r_best   <= r_didx;
                end
            end
            S_LEAF: begin
                if (r_dv) begin
                    r_is_par[par_rdata] <= 1'b1;
                end
                r_v     <= '0;
                r_found <= 1'b0;
                r_s     <= '0;
            end
            S_SN_PAR: begin
                if (r_v != n_used && r_is_par[r_v[VW-1:0]]) begin
                    r_v <= r_v + CW'(1);
                end
            end
            S_SN_LAT: begin
                r_par    <= par_rdata;
                r_cnt    <= '0;
                r_dv     <= 1'b0;
                r_sfound <= 1'b0;
            end
            S_SN_SCAN: begin
                if (r_dv && r_didx != r_v[VW-1:0] && r_didx != r_par
                    && (!r_sfound || dist_rdata < r_smin)) begin
                    r_sfound <= 1'b1;
                    r_smin   <= dist_rdata;
                    r_sw     <= r_didx;
                end
            end
            S_SN_END: begin
                if (!r_found || r_smin > r_best_d) begin
                    r_found  <= 1'b1;
                    r_best_d <= r_smin;
                    r_s      <= r_v[VW-1:0];
                    r_sn     <= r_sw;
                    r_spar   <= r_par;
                end
                r_v <= r_v + CW'(1);
            end
            S_SP_GET: begin
                r_dpar <= dist_rdata;
                r_cnt  <= '0;
                r_a    <= '0;
            end
            S_A_ORD: begin
            end
            S_A_CHK: begin
                if (ord_rdata == r_s) begin
                    r_a <= r_a + CW'(1);
                end else begin
                    r_oi <= ord_rdata;
                    r_b  <= r_a + CW'(1);
                end
            end
            S_B_ORD: begin
                if (r_b == n_used) begin
                    r_a <= r_a + CW'(1);
                end
            end
            S_B_PAR: begin
                if (ord_rdata == r_s) begin
                    r_b <= r_b + CW'(1);
                end else begin
                    r_oj <= ord_rdata;
                end
            end
            S_B_MEM: begin
                r_p <= par_rdata;
            end
            S_B_WR: begin
                r_b <= r_b + CW'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.alpha_value      = r_o_alpha;
    assign o_out.special_vertex   = r_o_special;
    assign o_out.special_neighbor = r_o_neighbor;
    assign o_out.not_computed     = r_o_nc;

    // Symmetric distance store
    anft_ram #(.WIDTH(DIST_BITS), .DEPTH(PAIR_DEPTH)) u_dist (
        .i_clk(i_clk), .i_we(dist_we), .i_waddr(dist_waddr), .i_wdata(dist_wdata),
        .i_re(dist_re), .i_raddr(dist_raddr), .o_rdata(dist_rdata)
    );

    // Symmetric beta store
    anft_ram #(.WIDTH(DIST_BITS), .DEPTH(PAIR_DEPTH)) u_beta (
        .i_clk(i_clk), .i_we(beta_we), .i_waddr(beta_waddr), .i_wdata(beta_wdata),
        .i_re(beta_re), .i_raddr(beta_raddr), .o_rdata(beta_rdata)
    );

    // Prim keys
    anft_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_VERTICES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_re(key_re), .i_raddr(key_raddr), .o_rdata(key_rdata)
    );

    // Tree parents
    anft_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_re(par_re), .i_raddr(par_raddr), .o_rdata(par_rdata)
    );

    // Insertion order
    anft_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_re(ord_re), .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    // Each commit adds a vertex not yet in the tree
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMMIT |-> !r_in_tree[r_best])
        else $error("commit picks a vertex already in the tree");

    // Tree size tracks the insertion step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMMIT |-> $countones(r_in_tree) == 32'(r_step))
        else $error("tree size out of step with insertion order");

    // Relaxation never touches a vertex already in the tree
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && key_we) |-> !r_in_tree[r_didx])
        else $error("key update of a tree vertex");

    // The special vertex is a leaf
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BROW |-> !r_is_par[r_s])
        else $error("special vertex is not a leaf");

    // A stalled read stays pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !out_free) |=> r_pend)
        else $error("pending read lost");

    // A finished compute shows a valid result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_o_valid && !r_o_nc && r_result_valid))
        else $error("compute result not delivered");

endmodule
